// File: src/runtime_budget_window_monitor_assert.svh
`ifndef RUNTIME_BUDGET_WINDOW_MONITOR_ASSERT_SVH
`define RUNTIME_BUDGET_WINDOW_MONITOR_ASSERT_SVH

// condition holds at every edge out of reset
`define RBWM_ASSERT_NOW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition in one cycle implies another in the next
`define RBWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rbwm_pkg.sv
package rbwm_pkg;

	localparam int GROUP_SLOTS_DEF = 256;
	localparam int PROC_SLOTS_DEF  = 256;
	localparam logic [5:0] WATCHED_RESET = 6'd10;

	typedef enum logic [1:0] {
		FN_SWITCH     = 2'd0,
		FN_SIGNAL     = 2'd1,
		FN_LOAD_GROUP = 2'd2,
		FN_LOAD_PROC  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [63:0] timestamp;
		logic [63:0] group_id;
		logic [31:0] process_id;
		logic [5:0]  signal_number;
		logic [63:0] period;
		logic [63:0] budget;
	} req_t;

	typedef struct packed {
		logic [1:0]  ok_events;
		logic [1:0]  fail_events;
		logic [63:0] ok_total;
		logic [63:0] fail_total;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] period;
		logic [63:0] budget;
		logic        state_valid;
		logic [63:0] window_start;
		logic [63:0] consumed_time;
		logic        window_open;
		logic        signal_seen;
	} grp_row_t;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] period;
		logic [63:0] budget;
	} proc_row_t;

	typedef enum logic {
		TBL_GROUP = 1'b0,
		TBL_PROC  = 1'b1
	} tbl_t;

	typedef enum logic [1:0] {
		KEY_LAST = 2'd0,
		KEY_GID  = 2'd1,
		KEY_PID  = 2'd2
	} key_sel_t;

	typedef enum logic [2:0] {
		GW_NONE      = 3'd0,
		GW_CHARGE    = 3'd1,
		GW_ROLL      = 3'd2,
		GW_SIGNAL    = 3'd3,
		GW_LOAD      = 3'd4,
		GW_INS_LOAD  = 3'd5,
		GW_INS_PROMO = 3'd6
	} gwr_t;

	typedef enum logic [1:0] {
		PW_NONE = 2'd0,
		PW_LOAD = 2'd1,
		PW_INS  = 2'd2
	} pwr_t;

	typedef struct packed {
		logic     accept;
		logic     srch_go;
		tbl_t     srch_tbl;
		key_sel_t srch_key;
		gwr_t     gwr;
		pwr_t     pwr;
		logic     set_fail;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  busy;
		logic  hit;
		logic  row_sv;
		logic  row_open;
		logic  g_full;
		logic  p_full;
		logic  chg_cond;
		logic  sig_match;
		logic  gid_nz;
		logic  rsp_block;
	} dp_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CHG_GO,
		S_CHG_WAIT,
		S_SW_CUR,
		S_PR_P_GO,
		S_PR_P_WAIT,
		S_PR_G_GO,
		S_PR_G_WAIT,
		S_TGT_GO,
		S_TGT_WAIT,
		S_LG_GO,
		S_LG_WAIT,
		S_LP_GO,
		S_LP_WAIT,
		S_DONE
	} state_t;

endpackage

// File: src/rbwm_ram.sv
module rbwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/rbwm_ctrl.sv
module rbwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rbwm_pkg::dp_sts_t sts,
	output rbwm_pkg::dp_cmd_t cmd
);

	rbwm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbwm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbwm_pkg::S_IDLE: begin
				if (req_valid) state_d = rbwm_pkg::S_DISPATCH;
			end
			rbwm_pkg::S_DISPATCH: begin
				unique case (sts.func)
					rbwm_pkg::FN_SWITCH: begin
						state_d = sts.chg_cond ? rbwm_pkg::S_CHG_GO : rbwm_pkg::S_SW_CUR;
					end
					rbwm_pkg::FN_SIGNAL: begin
						state_d = (sts.sig_match && sts.gid_nz) ? rbwm_pkg::S_PR_P_GO
							: rbwm_pkg::S_DONE;
					end
					rbwm_pkg::FN_LOAD_GROUP: state_d = rbwm_pkg::S_LG_GO;
					rbwm_pkg::FN_LOAD_PROC:  state_d = rbwm_pkg::S_LP_GO;
					default:                 state_d = rbwm_pkg::S_DONE;
				endcase
			end
			rbwm_pkg::S_CHG_GO:    state_d = rbwm_pkg::S_CHG_WAIT;
			rbwm_pkg::S_CHG_WAIT: begin
				if (!sts.busy) state_d = rbwm_pkg::S_SW_CUR;
			end
			rbwm_pkg::S_SW_CUR: begin
				state_d = sts.gid_nz ? rbwm_pkg::S_PR_P_GO : rbwm_pkg::S_DONE;
			end
			rbwm_pkg::S_PR_P_GO:   state_d = rbwm_pkg::S_PR_P_WAIT;
			rbwm_pkg::S_PR_P_WAIT: begin
				if (!sts.busy) state_d = sts.hit ? rbwm_pkg::S_PR_G_GO : rbwm_pkg::S_TGT_GO;
			end
			rbwm_pkg::S_PR_G_GO:   state_d = rbwm_pkg::S_PR_G_WAIT;
			rbwm_pkg::S_PR_G_WAIT: begin
				if (!sts.busy) state_d = rbwm_pkg::S_TGT_GO;
			end
			rbwm_pkg::S_TGT_GO:    state_d = rbwm_pkg::S_TGT_WAIT;
			rbwm_pkg::S_TGT_WAIT: begin
				if (!sts.busy) state_d = rbwm_pkg::S_DONE;
			end
			rbwm_pkg::S_LG_GO:     state_d = rbwm_pkg::S_LG_WAIT;
			rbwm_pkg::S_LG_WAIT: begin
				if (!sts.busy) state_d = rbwm_pkg::S_DONE;
			end
			rbwm_pkg::S_LP_GO:     state_d = rbwm_pkg::S_LP_WAIT;
			rbwm_pkg::S_LP_WAIT: begin
				if (!sts.busy) state_d = rbwm_pkg::S_DONE;
			end
			rbwm_pkg::S_DONE: begin
				if (!sts.rsp_block) state_d = rbwm_pkg::S_IDLE;
			end
			default: state_d = rbwm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{accept: 1'b0, srch_go: 1'b0, srch_tbl: rbwm_pkg::TBL_GROUP,
			srch_key: rbwm_pkg::KEY_GID, gwr: rbwm_pkg::GW_NONE,
			pwr: rbwm_pkg::PW_NONE, set_fail: 1'b0, finish: 1'b0};
		req_stall = (state_q != rbwm_pkg::S_IDLE);
		unique case (state_q) inside
			rbwm_pkg::S_IDLE: cmd.accept = req_valid;
			rbwm_pkg::S_CHG_GO: begin
				cmd.srch_go  = 1'b1;
				cmd.srch_key = rbwm_pkg::KEY_LAST;
			end
			rbwm_pkg::S_CHG_WAIT: begin
				if (!sts.busy && sts.hit && sts.row_sv) cmd.gwr = rbwm_pkg::GW_CHARGE;
			end
			rbwm_pkg::S_PR_P_GO: begin
				cmd.srch_go  = 1'b1;
				cmd.srch_tbl = rbwm_pkg::TBL_PROC;
				cmd.srch_key = rbwm_pkg::KEY_PID;
			end
			rbwm_pkg::S_PR_G_GO, rbwm_pkg::S_TGT_GO, rbwm_pkg::S_LG_GO: begin
				cmd.srch_go = 1'b1;
			end
			rbwm_pkg::S_PR_G_WAIT: begin
				if (!sts.busy && !sts.hit) begin
					if (!sts.g_full) cmd.gwr = rbwm_pkg::GW_INS_PROMO;
					else cmd.set_fail = 1'b1;
				end
			end
			rbwm_pkg::S_TGT_WAIT: begin
				if (!sts.busy && sts.hit) begin
					if (sts.func == rbwm_pkg::FN_SWITCH) cmd.gwr = rbwm_pkg::GW_ROLL;
					else if (sts.row_sv && sts.row_open) cmd.gwr = rbwm_pkg::GW_SIGNAL;
				end
			end
			rbwm_pkg::S_LG_WAIT: begin
				if (!sts.busy) begin
					if (sts.hit) cmd.gwr = rbwm_pkg::GW_LOAD;
					else if (!sts.g_full) cmd.gwr = rbwm_pkg::GW_INS_LOAD;
					else cmd.set_fail = 1'b1;
				end
			end
			rbwm_pkg::S_LP_GO: begin
				cmd.srch_go  = 1'b1;
				cmd.srch_tbl = rbwm_pkg::TBL_PROC;
				cmd.srch_key = rbwm_pkg::KEY_PID;
			end
			rbwm_pkg::S_LP_WAIT: begin
				if (!sts.busy) begin
					if (sts.hit) cmd.pwr = rbwm_pkg::PW_LOAD;
					else if (!sts.p_full) cmd.pwr = rbwm_pkg::PW_INS;
					else cmd.set_fail = 1'b1;
				end
			end
			rbwm_pkg::S_DONE: cmd.finish = !sts.rsp_block;
			default: ;
		endcase
	end

endmodule

// File: src/rbwm_dp.sv
`include "runtime_budget_window_monitor_assert.svh"

module rbwm_dp #(
	parameter int GROUP_SLOTS = rbwm_pkg::GROUP_SLOTS_DEF,
	parameter int PROC_SLOTS  = rbwm_pkg::PROC_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rbwm_pkg::req_t    req,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_data,
	output rbwm_pkg::rsp_t    rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  rbwm_pkg::dp_cmd_t cmd,
	output rbwm_pkg::dp_sts_t sts
);

	localparam int GAW = $clog2(GROUP_SLOTS);
	localparam int PAW = $clog2(PROC_SLOTS);
	localparam int GCW = $clog2(GROUP_SLOTS + 1);
	localparam int PCW = $clog2(PROC_SLOTS + 1);
	localparam int SCW = (GCW > PCW) ? GCW : PCW;

	rbwm_pkg::req_t    req_q;
	rbwm_pkg::rsp_t    rsp_q;
	logic              rsp_valid_q;
	logic [5:0]        watched_q;
	logic [63:0]       last_time_q, last_group_q, ok_cnt_q, fail_cnt_q;
	logic [1:0]        ev_ok_q, ev_fail_q;
	logic              fail_q;
	logic [GCW-1:0]    gcnt_q;
	logic [PCW-1:0]    pcnt_q;

	logic              busy_q, pend_q, hit_q;
	rbwm_pkg::tbl_t    tbl_q;
	logic [63:0]       key_q, key_d;
	logic [SCW-1:0]    idx_q, cnt_sel;
	logic              scan_end, match, rd_issue;

	rbwm_pkg::grp_row_t  grow, gwdata, chg_row, roll_row;
	rbwm_pkg::proc_row_t prow, pwdata;
	logic                g_re, g_we, p_re, p_we;
	logic [GAW-1:0]      g_waddr;
	logic [PAW-1:0]      p_waddr;

	logic [63:0] d_q, newcons, elapsed;
	logic [64:0] sum;
	logic        chg_close, chg_ok, chg_fail;
	logic        base_open, base_seen, roll_due, roll_ok, roll_fail;
	logic [63:0] base_ws;
	logic        inc_ok, inc_fail;

	rbwm_ram #(.WIDTH($bits(rbwm_pkg::grp_row_t)), .DEPTH(GROUP_SLOTS)) u_gram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(gwdata),
		.re(g_re), .raddr(idx_q[GAW-1:0]), .rdata(grow)
	);

	rbwm_ram #(.WIDTH($bits(rbwm_pkg::proc_row_t)), .DEPTH(PROC_SLOTS)) u_pram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(pwdata),
		.re(p_re), .raddr(idx_q[PAW-1:0]), .rdata(prow)
	);

	// key scan
	always_comb begin
		unique case (cmd.srch_key)
			rbwm_pkg::KEY_LAST: key_d = last_group_q;
			rbwm_pkg::KEY_GID:  key_d = req_q.group_id;
			rbwm_pkg::KEY_PID:  key_d = {32'd0, req_q.process_id};
			default:            key_d = '0;
		endcase
		cnt_sel  = (tbl_q == rbwm_pkg::TBL_GROUP) ? SCW'(gcnt_q) : SCW'(pcnt_q);
		scan_end = (idx_q == cnt_sel);
		match    = (tbl_q == rbwm_pkg::TBL_GROUP) ? (grow.key == key_q)
			: (prow.key == key_q[31:0]);
		rd_issue = busy_q && !pend_q && !scan_end;
		g_re     = rd_issue && (tbl_q == rbwm_pkg::TBL_GROUP);
		p_re     = rd_issue && (tbl_q == rbwm_pkg::TBL_PROC);
	end

	// charge
	always_comb begin
		sum       = {1'b0, grow.consumed_time} + {1'b0, d_q};
		newcons   = sum[64] ? '1 : sum[63:0];
		chg_close = grow.window_open && (grow.budget != 64'd0) && (newcons >= grow.budget);
		chg_ok    = chg_close && grow.signal_seen;
		chg_fail  = chg_close && !grow.signal_seen;
		chg_row               = grow;
		chg_row.consumed_time = newcons;
		chg_row.window_open   = grow.window_open && !chg_close;
	end

	// state creation and period roll
	always_comb begin
		base_ws   = grow.state_valid ? grow.window_start : 64'd0;
		base_open = grow.state_valid && grow.window_open;
		base_seen = grow.state_valid && grow.signal_seen;
		elapsed   = req_q.timestamp - base_ws;
		roll_due  = (grow.period != 64'd0) && (base_ws != 64'd0) && (elapsed >= grow.period);
		roll_ok   = roll_due && base_open && base_seen;
		roll_fail = roll_due && base_open && !base_seen;
		roll_row               = grow;
		roll_row.state_valid   = 1'b1;
		roll_row.window_start  = base_ws;
		roll_row.consumed_time = grow.state_valid ? grow.consumed_time : 64'd0;
		roll_row.window_open   = base_open;
		roll_row.signal_seen   = base_seen;
		if (grow.period != 64'd0 && (base_ws == 64'd0 || roll_due)) begin
			roll_row.window_start  = req_q.timestamp;
			roll_row.consumed_time = 64'd0;
			roll_row.window_open   = 1'b1;
			roll_row.signal_seen   = 1'b0;
		end
	end

	// table writes
	always_comb begin
		g_we     = (cmd.gwr != rbwm_pkg::GW_NONE);
		g_waddr  = idx_q[GAW-1:0];
		gwdata   = grow;
		inc_ok   = 1'b0;
		inc_fail = 1'b0;
		unique case (cmd.gwr) inside
			rbwm_pkg::GW_CHARGE: begin
				gwdata   = chg_row;
				inc_ok   = chg_ok;
				inc_fail = chg_fail;
			end
			rbwm_pkg::GW_ROLL: begin
				gwdata   = roll_row;
				inc_ok   = roll_ok;
				inc_fail = roll_fail;
			end
			rbwm_pkg::GW_SIGNAL: gwdata.signal_seen = 1'b1;
			rbwm_pkg::GW_LOAD: begin
				gwdata.period = req_q.period;
				gwdata.budget = req_q.budget;
			end
			rbwm_pkg::GW_INS_LOAD, rbwm_pkg::GW_INS_PROMO: begin
				g_waddr    = gcnt_q[GAW-1:0];
				gwdata     = '0;
				gwdata.key = req_q.group_id;
				if (cmd.gwr == rbwm_pkg::GW_INS_LOAD) begin
					gwdata.period = req_q.period;
					gwdata.budget = req_q.budget;
				end else begin
					gwdata.period = prow.period;
					gwdata.budget = prow.budget;
				end
			end
			default: ;
		endcase
		p_we    = (cmd.pwr != rbwm_pkg::PW_NONE);
		p_waddr = (cmd.pwr == rbwm_pkg::PW_INS) ? pcnt_q[PAW-1:0] : idx_q[PAW-1:0];
		pwdata  = '{key: req_q.process_id, period: req_q.period, budget: req_q.budget};
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		// time since the last switch, settled long before the charge step
		d_q <= req_q.timestamp - last_time_q;
		if (cmd.srch_go) begin
			key_q <= key_d;
		end
		if (cmd.finish) begin
			rsp_q <= '{ok_events: ev_ok_q, fail_events: ev_fail_q, ok_total: ok_cnt_q,
				fail_total: fail_cnt_q, status: fail_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			watched_q    <= rbwm_pkg::WATCHED_RESET;
			last_time_q  <= '0;
			last_group_q <= '0;
			ok_cnt_q     <= '0;
			fail_cnt_q   <= '0;
			ev_ok_q      <= '0;
			ev_fail_q    <= '0;
			fail_q       <= 1'b0;
			gcnt_q       <= '0;
			pcnt_q       <= '0;
			busy_q       <= 1'b0;
			pend_q       <= 1'b0;
			hit_q        <= 1'b0;
			tbl_q        <= rbwm_pkg::TBL_GROUP;
			idx_q        <= '0;
		end else begin
			if (cfg_we) watched_q <= cfg_data;
			if (cmd.finish) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (cmd.finish && req_q.func == rbwm_pkg::FN_SWITCH) begin
				last_time_q  <= req_q.timestamp;
				last_group_q <= req_q.group_id;
			end
			if (cmd.accept) begin
				ev_ok_q   <= '0;
				ev_fail_q <= '0;
				fail_q    <= 1'b0;
			end else begin
				if (inc_ok) begin
					ev_ok_q  <= ev_ok_q + 2'd1;
					ok_cnt_q <= ok_cnt_q + 64'd1;
				end
				if (inc_fail) begin
					ev_fail_q  <= ev_fail_q + 2'd1;
					fail_cnt_q <= fail_cnt_q + 64'd1;
				end
				if (cmd.set_fail) fail_q <= 1'b1;
			end
			if (cmd.gwr == rbwm_pkg::GW_INS_LOAD || cmd.gwr == rbwm_pkg::GW_INS_PROMO) begin
				gcnt_q <= gcnt_q + GCW'(1);
			end
			if (cmd.pwr == rbwm_pkg::PW_INS) pcnt_q <= pcnt_q + PCW'(1);
			if (cmd.srch_go) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
				hit_q  <= 1'b0;
				tbl_q  <= cmd.srch_tbl;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (pend_q) begin
					pend_q <= 1'b0;
					if (match) begin
						busy_q <= 1'b0;
						hit_q  <= 1'b1;
					end else begin
						idx_q <= idx_q + SCW'(1);
					end
				end else if (scan_end) begin
					busy_q <= 1'b0;
				end else begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.func      = req_q.func;
		sts.busy      = busy_q;
		sts.hit       = hit_q;
		sts.row_sv    = grow.state_valid;
		sts.row_open  = grow.window_open;
		sts.g_full    = (gcnt_q == GCW'(GROUP_SLOTS));
		sts.p_full    = (pcnt_q == PCW'(PROC_SLOTS));
		sts.chg_cond  = (last_time_q != 64'd0) && (req_q.timestamp > last_time_q)
			&& (last_group_q != 64'd0);
		sts.sig_match = (req_q.signal_number == watched_q);
		sts.gid_nz    = (req_q.group_id != 64'd0);
		sts.rsp_block = rsp_valid_q && rsp_stall;
	end

	`RBWM_ASSERT_NOW(a_gcnt_range, gcnt_q <= GCW'(GROUP_SLOTS), "group fill count past depth")
	`RBWM_ASSERT_NOW(a_pcnt_range, pcnt_q <= PCW'(PROC_SLOTS), "process fill count past depth")
	`RBWM_ASSERT_NEXT(a_read_pend, g_re || p_re, pend_q, "table read without compare")
	`RBWM_ASSERT_NOW(a_wr_idle, !((g_we || p_we) && busy_q), "table write during search")

endmodule

// File: src/runtime_budget_window_monitor.sv
// a skipped signal goes from dispatch straight to done; other items may add table scans
// each table scan reads and compares one slot at a time, stopping at the first hit or the fill count
// a switch runs up to four scans (charge, process lookup, promotion, target group)
// throughput: one item at a time, the next request is taken in the cycle after the result loads
// a result still waiting holds the next item at its last step until it is taken
// reset clears counters, last switch and fill counts and sets the signal register to 10; no clearing pass
module runtime_budget_window_monitor #(
	parameter int GROUP_SLOTS = rbwm_pkg::GROUP_SLOTS_DEF,
	parameter int PROC_SLOTS  = rbwm_pkg::PROC_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rbwm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rbwm_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [5:0]     cfg_data
);

	rbwm_pkg::dp_cmd_t cmd;
	rbwm_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rbwm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.sts(sts), .cmd(cmd)
	);

	rbwm_dp #(.GROUP_SLOTS(GROUP_SLOTS), .PROC_SLOTS(PROC_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.cmd(cmd), .sts(sts)
	);

endmodule

// File: dv/rbwm_checker.sv
`timescale 1ns / 1ps
module rbwm_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  rbwm_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  rbwm_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [5:0]     cfg_data,
	output int             fail_count,
	output int             pending
);
	import rbwm_pkg::*;

	localparam int NG = GROUP_SLOTS_DEF;
	localparam int NP = PROC_SLOTS_DEF;

	bit [63:0] g_key [NG];
	bit        g_ctl [NG];
	bit [63:0] g_per [NG];
	bit [63:0] g_bud [NG];
	bit        g_sv  [NG];
	bit [63:0] g_ws  [NG];
	bit [63:0] g_used[NG];
	bit        g_open[NG];
	bit        g_seen[NG];
	bit [31:0] p_key [NP];
	bit        p_vld [NP];
	bit [63:0] p_per [NP];
	bit [63:0] p_bud [NP];
	bit [63:0] prev_ts, prev_gid, ok_windows, failed_windows;
	bit [5:0]  watch;
	bit [1:0]  n_ok, n_fail;
	rsp_t      expected_rsp_q[$];

	assign pending = expected_rsp_q.size();

	function automatic int grp_lookup(bit [63:0] key);
		for (int i = 0; i < NG; i++)
			if (g_ctl[i] && g_key[i] == key) return i;
		return -1;
	endfunction

	function automatic int proc_lookup(bit [31:0] key);
		for (int i = 0; i < NP; i++)
			if (p_vld[i] && p_key[i] == key) return i;
		return -1;
	endfunction

	function automatic bit grp_store(bit [63:0] key, bit [63:0] per, bit [63:0] bud);
		int i;
		i = grp_lookup(key);
		if (i < 0) begin
			for (int j = 0; j < NG; j++)
				if (!g_ctl[j]) begin
					i = j;
					break;
				end
			if (i < 0) return 0;
			g_key[i] = key;
			g_ctl[i] = 1;
			g_sv[i] = 0;
			g_ws[i] = 0;
			g_used[i] = 0;
			g_open[i] = 0;
			g_seen[i] = 0;
		end
		g_per[i] = per;
		g_bud[i] = bud;
		return 1;
	endfunction

	function automatic bit proc_store(bit [31:0] key, bit [63:0] per, bit [63:0] bud);
		int i;
		i = proc_lookup(key);
		if (i < 0) begin
			for (int j = 0; j < NP; j++)
				if (!p_vld[j]) begin
					i = j;
					break;
				end
			if (i < 0) return 0;
			p_key[i] = key;
			p_vld[i] = 1;
		end
		p_per[i] = per;
		p_bud[i] = bud;
		return 1;
	endfunction

	function automatic void retire_window(int i);
		if (g_seen[i]) begin
			ok_windows++;
			n_ok++;
		end else begin
			failed_windows++;
			n_fail++;
		end
		g_open[i] = 0;
	endfunction

	function automatic bit adopt_proc_ctl(bit [31:0] pid, bit [63:0] gid);
		int p;
		p = proc_lookup(pid);
		if (p < 0 || grp_lookup(gid) >= 0) return 1;
		return grp_store(gid, p_per[p], p_bud[p]);
	endfunction

	function automatic void open_window(int i, bit [63:0] now);
		g_ws[i] = now;
		g_used[i] = 0;
		g_open[i] = 1;
		g_seen[i] = 0;
	endfunction

	function automatic bit context_switch(bit [63:0] now, bit [63:0] cur, bit [31:0] pid);
		bit ok;
		int i;
		bit [63:0] d;
		ok = 1;
		if (prev_ts != 0 && now > prev_ts && prev_gid != 0) begin
			i = grp_lookup(prev_gid);
			if (i >= 0 && g_sv[i]) begin
				d = now - prev_ts;
				g_used[i] = (g_used[i] > ~64'd0 - d) ? ~64'd0 : g_used[i] + d;
				if (g_open[i] && g_bud[i] != 0 && g_used[i] >= g_bud[i]) retire_window(i);
			end
		end
		if (cur != 0) begin
			ok = adopt_proc_ctl(pid, cur);
			i = grp_lookup(cur);
			if (i >= 0) begin
				if (!g_sv[i]) begin
					g_sv[i] = 1;
					g_ws[i] = 0;
					g_used[i] = 0;
					g_open[i] = 0;
					g_seen[i] = 0;
				end
				if (g_per[i] != 0) begin
					if (g_ws[i] == 0) open_window(i, now);
					else if (now - g_ws[i] >= g_per[i]) begin
						if (g_open[i]) retire_window(i);
						open_window(i, now);
					end
				end
			end
		end
		prev_ts = now;
		prev_gid = cur;
		return ok;
	endfunction

	function automatic rsp_t expected_response(req_t r);
		rsp_t e;
		bit ok;
		int i;
		n_ok = 0;
		n_fail = 0;
		ok = 1;
		case (r.func)
			FN_SWITCH: ok = context_switch(r.timestamp, r.group_id, r.process_id);
			FN_SIGNAL: begin
				if (r.signal_number == watch && r.group_id != 0) begin
					ok = adopt_proc_ctl(r.process_id, r.group_id);
					i = grp_lookup(r.group_id);
					if (i >= 0 && g_sv[i] && g_open[i]) g_seen[i] = 1;
				end
			end
			FN_LOAD_GROUP: ok = grp_store(r.group_id, r.period, r.budget);
			default: ok = proc_store(r.process_id, r.period, r.budget);
		endcase
		e.ok_events = n_ok;
		e.fail_events = n_fail;
		e.ok_total = ok_windows;
		e.fail_total = failed_windows;
		e.status = !ok;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < NG; i++) begin
				g_ctl[i] = 0;
				g_sv[i] = 0;
			end
			for (int i = 0; i < NP; i++) p_vld[i] = 0;
			prev_ts = 0;
			prev_gid = 0;
			ok_windows = 0;
			failed_windows = 0;
			watch = WATCHED_RESET;
			expected_rsp_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) watch = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected response %h", rsp);
					fail_count++;
				end else begin
					e = expected_rsp_q.pop_front();
					if (rsp.ok_events !== e.ok_events) begin
						$error("ok_events exp %0d got %0d", e.ok_events, rsp.ok_events);
						fail_count++;
					end
					if (rsp.fail_events !== e.fail_events) begin
						$error("fail_events exp %0d got %0d", e.fail_events, rsp.fail_events);
						fail_count++;
					end
					if (rsp.ok_total !== e.ok_total) begin
						$error("ok_total exp %0d got %0d", e.ok_total, rsp.ok_total);
						fail_count++;
					end
					if (rsp.fail_total !== e.fail_total) begin
						$error("fail_total exp %0d got %0d", e.fail_total, rsp.fail_total);
						fail_count++;
					end
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) expected_rsp_q.push_back(expected_response(req));
		end
	end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rbwm_pkg::*;

	localparam longint LIMIT = 20000000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       req_valid = 0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 0;
	rsp_t       rsp;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [5:0] cfg_data = '0;
	int         fail_count, pending;
	int         idle_pct = 0, stall_pct = 0;
	longint     cycles = 0;
	bit [63:0]  now = 1;
	bit [5:0]   watch = WATCHED_RESET;
	bit [63:0]  gid_pool[8] = '{1, 2, 3, 64'h8000_0000_0000_0000, 5, 6, 7,
		64'hFFFF_FFFF_FFFF_FFFF};
	bit [31:0]  pid_pool[8] = '{0, 1, 2, 3, 32'h8000_0000, 40, 41, 32'hFFFF_FFFF};

	always #6 clk = ~clk;

	runtime_budget_window_monitor u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rbwm_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t mk(func_t f, bit [63:0] ts, bit [63:0] gid, bit [31:0] pid,
		bit [5:0] sig, bit [63:0] per, bit [63:0] bud);
		req_t r;
		r.func = f;
		r.timestamp = ts;
		r.group_id = gid;
		r.process_id = pid;
		r.signal_number = sig;
		r.period = per;
		r.budget = bud;
		return r;
	endfunction

	task automatic send(req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic write_watch(bit [5:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		watch = v;
	endtask

	task automatic drain();
		req_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic bit [63:0] pick_gid();
		int k;
		k = $urandom_range(99);
		if (k < 8) return 0;
		if (k < 90) return gid_pool[$urandom_range(7)];
		return rand64();
	endfunction

	function automatic bit [63:0] pick_amount(int hi);
		int k;
		k = $urandom_range(99);
		if (k < 8) return 0;
		if (k < 11) return ~64'd0;
		return 64'($urandom_range(hi, 1));
	endfunction

	function automatic req_t random_item();
		int k;
		bit [31:0] pid;
		k = $urandom_range(99);
		pid = ($urandom_range(9) == 0) ? $urandom : pid_pool[$urandom_range(7)];
		if (k < 42) begin
			now += 64'($urandom_range(60));
			return mk(FN_SWITCH, now, pick_gid(), pid, 6'($urandom), rand64(), rand64());
		end
		if (k < 67)
			return mk(FN_SIGNAL, rand64(), pick_gid(), pid,
				($urandom_range(3) != 0) ? watch : 6'($urandom), rand64(), rand64());
		if (k < 80)
			return mk(FN_LOAD_GROUP, rand64(), pick_gid(), pid, 6'($urandom),
				pick_amount(400), pick_amount(200));
		if (k < 90)
			return mk(FN_LOAD_PROC, rand64(), rand64(), pid, 6'($urandom),
				pick_amount(400), pick_amount(200));
		return mk(func_t'($urandom_range(3)), rand64(), rand64(), $urandom, 6'($urandom),
			rand64(), rand64());
	endfunction

	initial begin
		int modes_idle[4] = '{0, 73, 0, 19};
		int modes_stall[4] = '{0, 0, 73, 19};
		bit [5:0] watch_set[4] = '{6'd0, 6'd63, 6'd10, 6'd27};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send(mk(FN_LOAD_GROUP, 0, 1, 0, 0, 100, 30));
		send(mk(FN_LOAD_PROC, 0, 0, 40, 0, 50, 10));
		send(mk(FN_LOAD_GROUP, 0, 0, 0, 0, 20, 5));
		send(mk(FN_SWITCH, 0, 1, 0, 0, 0, 0));
		send(mk(FN_SWITCH, 10, 1, 0, 0, 0, 0));
		send(mk(FN_SIGNAL, 0, 1, 0, watch, 0, 0));
		send(mk(FN_SIGNAL, 0, 1, 0, 6'd63, 0, 0));
		send(mk(FN_SWITCH, 50, 2, 40, 0, 0, 0));
		send(mk(FN_SWITCH, 70, 1, 0, 0, 0, 0));
		send(mk(FN_SWITCH, 200, 0, 0, 0, 0, 0));
		send(mk(FN_SWITCH, 300, 2, 40, 0, 0, 0));
		send(mk(FN_SWITCH, 360, 1, 0, 0, 0, 0));
		send(mk(FN_LOAD_GROUP, 0, 1, 0, 0, ~64'd0, ~64'd0));
		send(mk(FN_SWITCH, 100, 2, 0, 0, 0, 0));
		send(mk(FN_SWITCH, ~64'd0, 1, 0, 0, 0, 0));
		send(mk(FN_SWITCH, 1, 1, 0, 0, 0, 0));
		send(mk(FN_SWITCH, ~64'd0, 0, 0, 0, 0, 0));
		send(mk(FN_SIGNAL, 0, 0, 40, watch, 0, 0));
		send(mk(FN_SIGNAL, 0, 64'hFFFF_FFFF_FFFF_FFFF, 40, watch, 0, 0));
		send(mk(FN_LOAD_PROC, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send(mk(FN_SWITCH, 0, 0, 0, 0, 0, 0));
		now = 1000;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_watch((ph < 4) ? watch_set[ph] : 6'($urandom));
			idle_pct = modes_idle[ph % 4];
			stall_pct = modes_stall[ph % 4];
			repeat (125) send(random_item());
			drain();
		end

		// fill both tables, then run into the full cases
		idle_pct = 19;
		stall_pct = 19;
		for (int i = 0; i < 260; i++)
			send(mk(FN_LOAD_GROUP, 0, 64'(1000 + i), 0, 0, 64'($urandom_range(400)),
				64'($urandom_range(200))));
		for (int i = 0; i < 260; i++)
			send(mk(FN_LOAD_PROC, 0, 0, 32'(5000 + i), 0, 64'($urandom_range(400)),
				64'($urandom_range(200))));
		repeat (60) send(random_item());
		drain();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/rbwm_pkg.sv
src/rbwm_ram.sv
src/rbwm_ctrl.sv
src/rbwm_dp.sv
src/runtime_budget_window_monitor.sv
dv/rbwm_checker.sv
dv/testbench.sv
